[design/pfe_pkg.sv]
// ----------------------------------------------------------------------------
// pfe_pkg
// shared types and constants of the protobuf field encoder
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int FNUM_W = 29;   // field number width
  localparam int WT_W   = 3;    // wire type width, also the key shift
  localparam int VAL_W  = 64;   // value width
  localparam int KEY_W  = FNUM_W + WT_W;
  localparam int BYTE_W = 8;
  localparam int GRP_W  = 7;    // bits per varint group

  // decoupling queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;
  localparam int Q_CW    = 2;

  typedef enum logic [1:0] {
    REQ_VARINT  = 2'd0,
    REQ_STRING  = 2'd1,
    REQ_PAYLOAD = 2'd2
  } req_type_t;

  // classified request handed from front to back
  typedef struct packed {
    logic              is_raw;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } desc_t;

endpackage

[design/pfe_front.sv]
// ----------------------------------------------------------------------------
// pfe_front
// accepts requests, drops undefined types, builds the key and registers it
// ----------------------------------------------------------------------------
module pfe_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 in_req_type,
  input  logic [pfe_pkg::FNUM_W-1:0] in_field_number,
  input  logic [pfe_pkg::WT_W-1:0]   in_wire_type,
  input  logic [pfe_pkg::VAL_W-1:0]  in_value,
  output logic                       d_valid,
  output pfe_pkg::desc_t             d_desc,
  input  logic                       q_full
);

  logic           valid_r, valid_nxt;
  pfe_pkg::desc_t desc_r, desc_nxt;
  logic           accept, move, keep;

  assign full   = valid_r && q_full;
  assign move   = valid_r && !q_full;
  assign accept = push && !full;

  always_comb begin
    keep     = 1'b0;
    desc_nxt = desc_r;
    case (in_req_type)
      pfe_pkg::REQ_VARINT, pfe_pkg::REQ_STRING: begin
        keep = 1'b1;
      end
      pfe_pkg::REQ_PAYLOAD: begin
        keep = 1'b1;
      end
      default: keep = 1'b0;   // undefined type gives no bytes
    endcase
    if (accept) begin
      desc_nxt.is_raw = (in_req_type == pfe_pkg::REQ_PAYLOAD);
      desc_nxt.key    = {in_field_number, in_wire_type};
      desc_nxt.value  = in_value;
    end
    if (accept) begin
      valid_nxt = keep;
    end else if (move) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    desc_r <= desc_nxt;
  end

  assign d_valid = move;
  assign d_desc  = desc_r;

endmodule

[design/pfe_queue.sv]
// ----------------------------------------------------------------------------
// pfe_queue
// short request queue between front and back
// ----------------------------------------------------------------------------
module pfe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  pfe_pkg::desc_t wr_desc,
  output logic           q_full,
  input  logic           rd_en,
  output pfe_pkg::desc_t rd_desc,
  output logic           q_empty
);

  pfe_pkg::desc_t                mem_r [pfe_pkg::Q_DEPTH];
  logic [pfe_pkg::Q_AW-1:0]      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [pfe_pkg::Q_CW-1:0]      cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == pfe_pkg::Q_CW'(pfe_pkg::Q_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_desc = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wr_en ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd_en ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (wr_en) begin
      mem_r[wp_r] <= wr_desc;
    end
  end

endmodule

[design/pfe_back.sv]
// ----------------------------------------------------------------------------
// pfe_back
// serializes one request into varint or raw bytes, one byte per cycle while the byte channel is not held
// ----------------------------------------------------------------------------
module pfe_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  pfe_pkg::desc_t              q_desc,
  output logic                        q_pop,
  output logic                        empty,
  input  logic                        pop,
  output logic [pfe_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_VAL,
    ST_RAW
  } state_t;

  state_t                      state_r, state_nxt;
  logic [pfe_pkg::VAL_W-1:0]   sh_r, sh_nxt;
  logic [pfe_pkg::VAL_W-1:0]   val_r, val_nxt;
  logic                        ov_r, ov_nxt;
  logic [pfe_pkg::BYTE_W-1:0]  ob_r, ob_nxt;
  logic                        ol_r, ol_nxt;
  logic                        out_free, more;
  logic [pfe_pkg::GRP_W-1:0]   grp;

  assign out_free = !ov_r || pop;
  assign grp      = sh_r[pfe_pkg::GRP_W-1:0];
  assign more     = |sh_r[pfe_pkg::VAL_W-1:pfe_pkg::GRP_W];

  always_comb begin
    state_nxt = state_r;
    sh_nxt    = sh_r;
    val_nxt   = val_r;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    ov_nxt    = ov_r && !pop;
    q_pop     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          sh_nxt    = pfe_pkg::VAL_W'(q_desc.key);
          val_nxt   = q_desc.value;
          state_nxt = q_desc.is_raw ? ST_RAW : ST_KEY;
        end
      end
      ST_KEY: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          ob_nxt = {more, grp};
          ol_nxt = 1'b0;
          sh_nxt = sh_r >> pfe_pkg::GRP_W;
          if (!more) begin
            sh_nxt    = val_r;
            state_nxt = ST_VAL;
          end
        end
      end
      ST_VAL: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          ob_nxt = {more, grp};
          ol_nxt = !more;
          sh_nxt = sh_r >> pfe_pkg::GRP_W;
          if (!more) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RAW: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = val_r[pfe_pkg::BYTE_W-1:0];
          ol_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    sh_r  <= sh_nxt;
    val_r <= val_nxt;
    ob_r  <= ob_nxt;
    ol_r  <= ol_nxt;
  end

  assign empty    = !ov_r;
  assign out_byte = ob_r;
  assign out_last = ol_r;

endmodule

[design/protobuf_field_encoder_top.sv]
// ----------------------------------------------------------------------------
// protobuf_field_encoder_top
// protobuf wire-format field encoder: key and varint value, string header,
// and a single raw payload byte, one serialized byte per result
// ----------------------------------------------------------------------------
// path: the first byte of a request passes the front register, the queue and the
//   sequencer state before it is registered on the result ports
// sequencing: the byte sequencer in the back takes a request from the queue in its
//   idle state, then sends its bytes; it takes no new request until the last is out
// reset: synchronous active-low rst_n clears the front valid, queue pointers,
//   sequencer state and output valid; no memory clearing is needed
module protobuf_field_encoder_top (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 in_req_type,
  input  logic [pfe_pkg::FNUM_W-1:0] in_field_number,
  input  logic [pfe_pkg::WT_W-1:0]   in_wire_type,
  input  logic [pfe_pkg::VAL_W-1:0]  in_value,
  // byte channel
  output logic                       empty,
  input  logic                       pop,
  output logic [pfe_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_last
);

  // classified request from front into the queue
  logic           f_valid;
  pfe_pkg::desc_t f_desc;
  // queue head towards the back
  logic           q_full, q_empty, q_pop;
  pfe_pkg::desc_t q_desc;

  // front: takes a request, drops undefined types, builds the key
  pfe_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_req_type     (in_req_type),
    .in_field_number (in_field_number),
    .in_wire_type    (in_wire_type),
    .in_value        (in_value),
    .d_valid         (f_valid),
    .d_desc          (f_desc),
    .q_full          (q_full)
  );

  // two-entry queue so front and back stall independently
  pfe_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_valid),
    .wr_desc (f_desc),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_desc (q_desc),
    .q_empty (q_empty)
  );

  // back: emits key and value groups lsb first, or the raw byte
  pfe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_desc   (q_desc),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule
